// ----- hw/rtl/oels_pkg.sv -----
// Package for the one-euro landmark smoother: field widths, register
// indexes, fixed-point constants and reset values.
// No dependencies.
package oels_pkg;

  localparam int unsigned MAX_POINTS_DEF = 128;

  localparam int unsigned PT_W     = 7;
  localparam int unsigned VAL_W    = 24;
  localparam int unsigned RATE_W   = 15;
  localparam int unsigned DS_W     = 32;
  localparam int unsigned CUT_W    = 24;
  localparam int unsigned CFG_W    = 16;
  localparam int unsigned CFG_IDX_W = 2;

  // Quotient bits of the smoothing factor (Q0.16)
  localparam int unsigned ALPHA_BITS = 16;

  localparam logic [CFG_IDX_W-1:0] REG_MIN_CUTOFF   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_GAIN   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DERIV_CUTOFF = 2'd2;

  localparam logic [CFG_W-1:0] MIN_CUTOFF_RST   = 16'd307;
  localparam logic [CFG_W-1:0] SPEED_GAIN_RST   = 16'd1311;
  localparam logic [CFG_W-1:0] DERIV_CUTOFF_RST = 16'd256;

  // round(2*pi*2^16)
  localparam logic [18:0] TWO_PI_Q16 = 19'd411775;
  // 1 Hz in Q7.8
  localparam logic [RATE_W-1:0] RATE_FLOOR = 15'd256;

  localparam logic MODE_FILTER = 1'b0;
  localparam logic MODE_CLEAR  = 1'b1;

endpackage

// ----- hw/rtl/oels_div.sv -----
// Pipelined restoring divider, one quotient bit per stage, for num < den.
// Depends on oels_pkg.
module oels_div #(
  parameter int unsigned W  = 36,
  parameter int unsigned QB = oels_pkg::ALPHA_BITS
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [W-1:0]  num_i,
  input  logic [W-1:0]  den_i,
  output logic [QB-1:0] quo_o
);

  logic [W-1:0]  rem_q [1:QB];
  logic [W-1:0]  den_q [1:QB];
  logic [QB-1:0] quo_q [1:QB];
  logic [W-1:0]  rem_d [1:QB];
  logic [QB-1:0] quo_d [1:QB];

  // One restoring step: shift the remainder, subtract when it fits
  function automatic logic [W+QB-1:0] div_step(input logic [W-1:0]  r,
                                               input logic [W-1:0]  d,
                                               input logic [QB-1:0] q);
    logic [W:0] sh;
    sh = {r, 1'b0};
    if (sh >= {1'b0, d}) begin
      return {W'(sh - {1'b0, d}), q[QB-2:0], 1'b1};
    end
    return {W'(sh), q[QB-2:0], 1'b0};
  endfunction

  always_comb begin
    {rem_d[1], quo_d[1]} = div_step(num_i, den_i, '0);
    for (int k = 2; k <= QB; k++) begin
      {rem_d[k], quo_d[k]} = div_step(rem_q[k-1], den_q[k-1], quo_q[k-1]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[1] <= rem_d[1];
      quo_q[1] <= quo_d[1];
      den_q[1] <= den_i;
      for (int k = 2; k <= QB; k++) begin
        rem_q[k] <= rem_d[k];
        quo_q[k] <= quo_d[k];
        den_q[k] <= den_q[k-1];
      end
    end
  end

  assign quo_o = quo_q[QB];

endmodule

// ----- hw/rtl/one_euro_landmark_smoother_top.sv -----
// One-euro landmark smoother: per point/axis state memory with a
// 40-stage read-modify-write pipeline. Depends on oels_pkg and oels_div.
// The result is registered after the last stage; one sample per cycle while the output is not stalled.
// A sample whose entry is still in flight waits until the earlier one is
// written back; a clear transaction waits until the pipeline is empty.
// Reset clears the started flags and loads the register defaults; the
// value memory has no clearing pass and is read only after a write.
module one_euro_landmark_smoother_top #(
  parameter int unsigned MAX_POINTS = oels_pkg::MAX_POINTS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [6:0] point_index, [7] axis, [31:8] sample_value, [46:32] sample_rate
  input  logic [47:0] s_axis_tdata_i,
  // [0] mode
  input  logic        s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [23:0] smoothed_value, [30:24] out_point_index, [31] out_axis
  output logic [31:0] m_axis_tdata_o,
  input  logic                               cfg_we_i,
  input  logic [oels_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [oels_pkg::CFG_W-1:0]         cfg_wdata_i
);

  localparam int unsigned ENTRIES = 2 * MAX_POINTS;
  localparam int unsigned IW      = $clog2(ENTRIES);
  localparam int unsigned DL      = oels_pkg::ALPHA_BITS;
  localparam int unsigned ST_NUMD = 2;
  localparam int unsigned ST_AD   = ST_NUMD + DL;
  localparam int unsigned ST_DSP  = ST_AD + 1;
  localparam int unsigned ST_DS   = ST_DSP + 1;
  localparam int unsigned ST_MAGP = ST_DS + 1;
  localparam int unsigned ST_CUT  = ST_MAGP + 1;
  localparam int unsigned ST_NUMV = ST_CUT + 1;
  localparam int unsigned ST_AV   = ST_NUMV + DL;
  localparam int unsigned NST     = ST_AV + 1;
  localparam int unsigned MEM_W   = oels_pkg::VAL_W + oels_pkg::DS_W;

  typedef struct packed {
    logic                      first;
    logic [6:0]                point;
    logic                      axis;
    logic [IW-1:0]             idx;
    logic signed [23:0]        x;
    logic [14:0]               rate;
    logic signed [23:0]        s;
    logic signed [31:0]        ds;
    logic signed [31:0]        dx;
  } info_t;

  function automatic logic [14:0] rate_eff(input logic [14:0] r);
    return (r < oels_pkg::RATE_FLOOR) ? oels_pkg::RATE_FLOOR : r;
  endfunction

  // Configuration registers
  logic [15:0] min_cut_q, gain_q, dcut_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_cut_q <= oels_pkg::MIN_CUTOFF_RST;
      gain_q    <= oels_pkg::SPEED_GAIN_RST;
      dcut_q    <= oels_pkg::DERIV_CUTOFF_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        oels_pkg::REG_MIN_CUTOFF:   min_cut_q <= cfg_wdata_i;
        oels_pkg::REG_SPEED_GAIN:   gain_q    <= cfg_wdata_i;
        oels_pkg::REG_DERIV_CUTOFF: dcut_q    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Input fields
  logic [6:0]         in_point;
  logic               in_axis;
  logic signed [23:0] in_x;
  logic [14:0]        in_rate;
  logic [IW-1:0]      in_idx;
  logic               in_range;

  assign in_point = s_axis_tdata_i[6:0];
  assign in_axis  = s_axis_tdata_i[7];
  assign in_x     = $signed(s_axis_tdata_i[31:8]);
  assign in_rate  = s_axis_tdata_i[46:32];
  assign in_idx   = IW'({in_point, in_axis});
  assign in_range = 32'(in_point) < MAX_POINTS;

  // Pipeline state
  logic [NST:1]       vld_q;
  logic [NST:1]       vld_d;
  info_t              info_q [1:NST];
  info_t              info_d [1:NST];
  logic               out_vld_q;
  logic [31:0]        out_data_q;
  logic [ENTRIES-1:0] started_q;
  logic [MEM_W-1:0]   mem_q [ENTRIES];
  logic [MEM_W-1:0]   rd_q;

  logic en, hazard, busy, acc;

  assign en = !out_vld_q || m_axis_tready_i;

  always_comb begin
    hazard = 1'b0;
    for (int k = 1; k <= NST; k++) begin
      if (vld_q[k] && (info_q[k].idx == in_idx)) hazard = 1'b1;
    end
  end

  assign busy = |vld_q;
  assign s_axis_tready_o = en &&
      ((s_axis_tuser_i == oels_pkg::MODE_CLEAR) ? !busy : !hazard);
  assign acc = s_axis_tvalid_i && s_axis_tready_o;

  // Stage 1 -> 2: derivative cutoff numerator and raw derivative product
  logic [34:0]        numd_q;
  logic signed [40:0] dxp_q;
  logic signed [24:0] sub1;

  assign sub1 = 25'(info_q[1].x) - 25'($signed(rd_q[MEM_W-1:oels_pkg::DS_W]));

  always_ff @(posedge clk_i) begin
    if (en) begin
      numd_q <= 35'(dcut_q) * 35'(oels_pkg::TWO_PI_Q16);
      dxp_q  <= 41'(sub1) * 41'($signed({1'b0, info_q[1].rate}));
    end
  end

  // Stage 2: derivative clamp, divider feed
  logic signed [40:0] dx_sh;
  logic signed [31:0] dx_c;
  logic [35:0]        dend;
  logic [15:0]        ad;

  assign dx_sh = dxp_q >>> 8;
  always_comb begin
    if (dx_sh > 41'sd2147483647)       dx_c = 32'sh7FFFFFFF;
    else if (dx_sh < -41'sd2147483648) dx_c = 32'sh80000000;
    else                               dx_c = 32'(dx_sh);
  end
  assign dend = 36'(numd_q) + (36'(rate_eff(info_q[ST_NUMD].rate)) << 16);

  oels_div #(.W(36), .QB(oels_pkg::ALPHA_BITS)) u_div_d (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (36'(numd_q)),
    .den_i (dend),
    .quo_o (ad)
  );

  // Derivative mix
  logic signed [32:0] ds_diff;
  logic signed [49:0] pds_q;
  logic signed [49:0] pds_r;
  logic signed [49:0] ds_sum;
  logic signed [31:0] ds_new;

  assign ds_diff = 33'(info_q[ST_AD].dx) - 33'(info_q[ST_AD].ds);
  always_ff @(posedge clk_i) begin
    if (en) pds_q <= 50'($signed({1'b0, ad})) * 50'(ds_diff);
  end

  assign pds_r  = (pds_q + 50'sd32768) >>> 16;
  assign ds_sum = 50'(info_q[ST_DSP].ds) + pds_r;
  always_comb begin
    if (ds_sum > 50'sd2147483647)       ds_new = 32'sh7FFFFFFF;
    else if (ds_sum < -50'sd2147483648) ds_new = 32'sh80000000;
    else                                ds_new = 32'(ds_sum);
  end

  // Value cutoff
  logic [31:0] mag;
  logic [47:0] magp_q;
  logic [32:0] cut_sum;
  logic [23:0] cut_q;
  logic [42:0] numv_q;
  logic [43:0] denv;
  logic [15:0] av;

  assign mag = info_q[ST_DS].ds[31] ? 32'(~info_q[ST_DS].ds + 32'sd1)
                                    : 32'(info_q[ST_DS].ds);
  assign cut_sum = 33'(min_cut_q) + 33'(magp_q[47:16]);

  always_ff @(posedge clk_i) begin
    if (en) begin
      magp_q <= 48'(mag) * 48'(gain_q);
      cut_q  <= (cut_sum > 33'hFFFFFF) ? 24'hFFFFFF : cut_sum[23:0];
      numv_q <= 43'(cut_q) * 43'(oels_pkg::TWO_PI_Q16);
    end
  end

  assign denv = 44'(numv_q) + (44'(rate_eff(info_q[ST_NUMV].rate)) << 16);

  oels_div #(.W(44), .QB(oels_pkg::ALPHA_BITS)) u_div_v (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (44'(numv_q)),
    .den_i (denv),
    .quo_o (av)
  );

  // Value mix and write-back
  logic signed [24:0] v_diff;
  logic signed [41:0] vp_q;
  logic signed [41:0] vp_r;
  logic signed [41:0] v_sum;
  logic signed [23:0] v_res;
  logic signed [23:0] wr_val;
  logic signed [31:0] wr_ds;

  assign v_diff = 25'(info_q[ST_AV].x) - 25'(info_q[ST_AV].s);
  always_ff @(posedge clk_i) begin
    if (en) vp_q <= 42'($signed({1'b0, av})) * 42'(v_diff);
  end

  assign vp_r  = (vp_q + 42'sd32768) >>> 16;
  assign v_sum = 42'(info_q[NST].s) + vp_r;
  always_comb begin
    if (v_sum > 42'sd8388607)       v_res = 24'sh7FFFFF;
    else if (v_sum < -42'sd8388608) v_res = 24'sh800000;
    else                            v_res = 24'(v_sum);
  end
  assign wr_val = info_q[NST].first ? info_q[NST].x : v_res;
  assign wr_ds  = info_q[NST].first ? 32'sd0 : info_q[NST].ds;

  // Pipeline advance with per-stage overrides
  always_comb begin
    vld_d[1]           = acc && (s_axis_tuser_i == oels_pkg::MODE_FILTER) && in_range;
    info_d[1]          = info_q[1];
    info_d[1].first    = !started_q[in_idx];
    info_d[1].point    = in_point;
    info_d[1].axis     = in_axis;
    info_d[1].idx      = in_idx;
    info_d[1].x        = in_x;
    info_d[1].rate     = in_rate;
    for (int k = 2; k <= NST; k++) begin
      vld_d[k]  = vld_q[k-1];
      info_d[k] = info_q[k-1];
    end
    info_d[2].s     = $signed(rd_q[MEM_W-1:oels_pkg::DS_W]);
    info_d[2].ds    = $signed(rd_q[oels_pkg::DS_W-1:0]);
    info_d[3].dx    = dx_c;
    info_d[ST_DS].ds = ds_new;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      vld_q     <= vld_d;
      out_vld_q <= vld_q[NST];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 1; k <= NST; k++) info_q[k] <= info_d[k];
      out_data_q <= {info_q[NST].axis, info_q[NST].point, wr_val};
    end
  end

  // Started flags: clear on a clear transaction, set on write-back
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q <= '0;
    end else begin
      if (acc && (s_axis_tuser_i == oels_pkg::MODE_CLEAR)) started_q <= '0;
      if (en && vld_q[NST]) started_q[info_q[NST].idx] <= 1'b1;
    end
  end

  // State memory: smoothed value above smoothed derivative
  always_ff @(posedge clk_i) begin
    if (en) rd_q <= mem_q[in_idx];
    if (en && vld_q[NST]) mem_q[info_q[NST].idx] <= {wr_val, wr_ds};
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_data_q;

`ifndef ASSERT_OFF
  a_clear_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (acc && (s_axis_tuser_i == oels_pkg::MODE_CLEAR)) |-> !busy)
    else $error("clear transaction accepted with samples in flight");

  a_no_entry_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
      vld_d[1] && en |-> !hazard)
    else $error("sample accepted while its entry is in flight");

  a_flag_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (en && vld_q[NST]) |=> started_q[$past(info_q[NST].idx)])
    else $error("started flag not set after write-back");

  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
      $rose(out_vld_q) |-> $past(vld_q[NST]))
    else $error("result appeared without a finished sample");
`endif

endmodule

// ----- dv/tb_top.sv -----
// Self-checking bench for one_euro_landmark_smoother_top: a stream driver,
// a result monitor and a fixed-point one-euro filter predictor.
// Depends on oels_pkg and the RTL of the block.
module tb_top;

  localparam int unsigned ENTRY_CNT  = 2 * oels_pkg::MAX_POINTS_DEF;
  localparam int unsigned LATENCY    = 41;
  localparam int unsigned STALL_MAX  = 3000;
  localparam longint      VAL_HI     = 64'sd8388607;
  localparam longint      VAL_LO     = -64'sd8388608;
  localparam longint      DS_HI      = 64'sd2147483647;
  localparam longint      DS_LO      = -64'sd2147483648;

  typedef struct packed {
    logic                              mode;
    logic [oels_pkg::PT_W-1:0]         pt;
    logic                              axis;
    logic signed [oels_pkg::VAL_W-1:0] val;
    logic [oels_pkg::RATE_W-1:0]       rate;
  } sample_t;

  // laid out as on m_axis_tdata_o: axis on top, value in the low bits
  typedef struct packed {
    logic                              axis;
    logic [oels_pkg::PT_W-1:0]         pt;
    logic signed [oels_pkg::VAL_W-1:0] val;
  } smoothed_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid_i = 1'b0;
  logic s_axis_tready_o;
  logic [47:0] s_axis_tdata_i = '0;
  logic s_axis_tuser_i = 1'b0;
  logic m_axis_tvalid_o;
  logic m_axis_tready_i = 1'b0;
  logic [31:0] m_axis_tdata_o;
  logic cfg_we_i = 1'b0;
  logic [oels_pkg::CFG_IDX_W-1:0] cfg_idx_i = oels_pkg::REG_MIN_CUTOFF;
  logic [oels_pkg::CFG_W-1:0] cfg_wdata_i = '0;

  one_euro_landmark_smoother_top dut (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // predictor state
  longint unsigned min_cut, gain, d_cut;
  longint          val_mem [ENTRY_CNT];
  longint          deriv_mem [ENTRY_CNT];
  bit              started [ENTRY_CNT];

  sample_t   sample_q[$];
  smoothed_t smooth_q[$];
  sample_t   cur;
  bit        took = 1'b0;
  bit        hold_send = 1'b0;
  int        send_idle = 0, recv_idle = 0;
  int        fails = 0;
  int        quiet = 0;
  longint    last_val [ENTRY_CNT];

  function automatic longint unsigned smoothing_factor(longint unsigned cutoff,
                                                       longint unsigned rate_eff);
    longint unsigned num, den;
    num = cutoff * 64'd411775;
    den = num + (rate_eff << 16);
    return (num << 16) / den;
  endfunction

  function automatic longint blend(longint old, longint nw, longint unsigned a);
    return old + ((longint'(a) * (nw - old) + 64'sd32768) >>> 16);
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  task automatic euro_filter_step(sample_t it);
    int unsigned     e;
    longint          x, s, dx, ds, res;
    longint unsigned r_eff, mag, cut;
    smoothed_t       o;
    if (it.mode == oels_pkg::MODE_CLEAR) begin
      foreach (started[i]) started[i] = 1'b0;
      return;
    end
    e = it.pt * 2 + it.axis;
    x = longint'(it.val);
    if (!started[e]) begin
      res = x;
      ds = 0;
    end else begin
      r_eff = it.rate < oels_pkg::RATE_FLOOR ? 64'd256 : 64'(it.rate);
      s = val_mem[e];
      dx = clip(((x - s) * longint'({1'b0, it.rate})) >>> 8, DS_LO, DS_HI);
      ds = clip(blend(deriv_mem[e], dx, smoothing_factor(d_cut, r_eff)), DS_LO, DS_HI);
      mag = ds < 0 ? longint'(-ds) : longint'(ds);
      cut = min_cut + ((mag * gain) >> 16);
      if (cut > 64'hFFFFFF) cut = 64'hFFFFFF;
      res = clip(blend(s, x, smoothing_factor(cut, r_eff)), VAL_LO, VAL_HI);
    end
    val_mem[e] = res;
    deriv_mem[e] = ds;
    started[e] = 1'b1;
    o.val = res[oels_pkg::VAL_W-1:0];
    o.pt = it.pt;
    o.axis = it.axis;
    smooth_q.push_back(o);
  endtask

  // sender: acceptance at the rising edge
  always @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      euro_filter_step(cur);
      void'(sample_q.pop_front());
      took <= 1'b1;
    end
  end

  always @(negedge clk_i) begin
    took <= 1'b0;
    if (rst_ni && (!s_axis_tvalid_i || took)) begin
      if (sample_q.size() > 0 && !hold_send && $urandom_range(99, 0) >= send_idle) begin
        cur = sample_q[0];
        s_axis_tvalid_i <= 1'b1;
        s_axis_tdata_i <= {1'b0, cur.rate, cur.val, cur.axis, cur.pt};
        s_axis_tuser_i <= cur.mode;
      end else begin
        s_axis_tvalid_i <= 1'b0;
      end
    end
    m_axis_tready_i <= rst_ni && ($urandom_range(99, 0) >= recv_idle);
  end

  // monitor and watchdog
  always @(posedge clk_i) begin
    smoothed_t got, want;
    if (m_axis_tvalid_o && m_axis_tready_i) begin
      got = m_axis_tdata_o;
      if (smooth_q.size() == 0) begin
        $error("unexpected result %h", m_axis_tdata_o);
        fails++;
      end else begin
        want = smooth_q.pop_front();
        if (got.val !== want.val) begin
          $error("smoothed_value expected %0d actual %0d", want.val, got.val);
          fails++;
        end
        if (got.pt !== want.pt) begin
          $error("out_point_index expected %0d actual %0d", want.pt, got.pt);
          fails++;
        end
        if (got.axis !== want.axis) begin
          $error("out_axis expected %0d actual %0d", want.axis, got.axis);
          fails++;
        end
      end
    end
    if ((m_axis_tvalid_o && m_axis_tready_i) || (s_axis_tvalid_i && s_axis_tready_o))
      quiet = 0;
    else
      quiet++;
    if (quiet >= STALL_MAX) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic drain();
    wait (sample_q.size() == 0 && smooth_q.size() == 0);
    repeat (LATENCY + 4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [oels_pkg::CFG_IDX_W-1:0] idx,
                           logic [oels_pkg::CFG_W-1:0] v);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      oels_pkg::REG_MIN_CUTOFF:   min_cut = v;
      oels_pkg::REG_SPEED_GAIN:   gain = v;
      oels_pkg::REG_DERIV_CUTOFF: d_cut = v;
      default: ;
    endcase
  endtask

  task automatic push(logic mode, int pt, logic axis, longint v, int rate);
    sample_t it;
    it.mode = mode;
    it.pt = pt[oels_pkg::PT_W-1:0];
    it.axis = axis;
    it.val = v[oels_pkg::VAL_W-1:0];
    it.rate = rate[oels_pkg::RATE_W-1:0];
    sample_q.push_back(it);
    if (mode == oels_pkg::MODE_FILTER) last_val[pt * 2 + int'(axis)] = v;
  endtask

  // mostly smooth tracks on a few points, with jumps, clears and noise
  task automatic add_random(int n);
    int pt, ax, rate, pick;
    longint v;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99, 0);
      pt = $urandom_range(99, 0) < 80 ? $urandom_range(7, 0) : $urandom_range(127, 0);
      ax = $urandom_range(1, 0);
      case ($urandom_range(9, 0))
        0:       rate = $urandom_range(255, 0);
        1:       rate = $urandom_range(32767, 30721);
        2:       rate = $urandom_range(32767, 0);
        default: rate = $urandom_range(30720, 7680);
      endcase
      if (pick < 2) begin
        push(oels_pkg::MODE_CLEAR, $urandom_range(127, 0), 1'($urandom_range(1, 0)),
             $urandom, rate);
      end else if (pick < 12) begin
        push(oels_pkg::MODE_FILTER, pt, 1'(ax),
             longint'($signed($urandom_range(24'hFFFFFF, 0) << 8)) >>> 8, rate);
      end else begin
        v = last_val[pt * 2 + ax] + $signed($urandom_range(8191, 0)) - 4096;
        if (pick < 20) v = v + $signed($urandom_range(2000000, 0)) - 1000000;
        push(oels_pkg::MODE_FILTER, pt, 1'(ax), clip(v, VAL_LO, VAL_HI), rate);
      end
    end
  endtask

  initial begin
    min_cut = oels_pkg::MIN_CUTOFF_RST;
    gain = oels_pkg::SPEED_GAIN_RST;
    d_cut = oels_pkg::DERIV_CUTOFF_RST;
    foreach (started[i]) begin
      started[i] = 1'b0;
      last_val[i] = 0;
    end
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    send_idle = 16;
    recv_idle = 63;

    // directed: extremes, rate corners, clear and restart
    push(oels_pkg::MODE_FILTER, 0, 1'b0, VAL_HI, 30720);
    push(oels_pkg::MODE_FILTER, 0, 1'b0, VAL_LO, 32767);
    push(oels_pkg::MODE_FILTER, 0, 1'b0, VAL_HI, 32767);
    push(oels_pkg::MODE_FILTER, 0, 1'b0, 0, 0);
    push(oels_pkg::MODE_FILTER, 0, 1'b0, 1000, 255);
    push(oels_pkg::MODE_FILTER, 127, 1'b1, VAL_LO, 30720);
    push(oels_pkg::MODE_FILTER, 127, 1'b1, VAL_HI, 30720);
    push(oels_pkg::MODE_FILTER, 127, 1'b1, VAL_HI, 256);
    push(oels_pkg::MODE_FILTER, 85, 1'b0, -12345, 7680);
    push(oels_pkg::MODE_FILTER, 85, 1'b0, -12000, 7680);
    push(oels_pkg::MODE_CLEAR, 127, 1'b1, -1, 32767);
    push(oels_pkg::MODE_FILTER, 0, 1'b0, 5555, 30720);
    push(oels_pkg::MODE_FILTER, 0, 1'b0, 5600, 30720);
    push(oels_pkg::MODE_FILTER, 42, 1'b1, 2796202, 21845);
    push(oels_pkg::MODE_FILTER, 42, 1'b1, -2796203, 10922);
    drain();

    for (int blk = 0; blk < 6; blk++) begin
      case (blk)
        1: begin  // holding filters: zero cutoffs
          write_reg(oels_pkg::REG_MIN_CUTOFF, 16'd0);
          write_reg(oels_pkg::REG_SPEED_GAIN, 16'd0);
          write_reg(oels_pkg::REG_DERIV_CUTOFF, 16'd0);
        end
        2: begin
          write_reg(oels_pkg::REG_MIN_CUTOFF, 16'hFFFF);
          write_reg(oels_pkg::REG_SPEED_GAIN, 16'hFFFF);
          write_reg(oels_pkg::REG_DERIV_CUTOFF, 16'hFFFF);
          send_idle = 63;
          recv_idle = 16;
        end
        3: begin
          write_reg(oels_pkg::REG_MIN_CUTOFF, 16'd1);
          write_reg(oels_pkg::REG_SPEED_GAIN, 16'hFFFF);
          write_reg(oels_pkg::REG_DERIV_CUTOFF, 16'd1);
        end
        4: begin
          write_reg(oels_pkg::REG_MIN_CUTOFF, 16'($urandom_range(65535, 1)));
          write_reg(oels_pkg::REG_SPEED_GAIN, 16'($urandom_range(65535, 0)));
          write_reg(oels_pkg::REG_DERIV_CUTOFF, 16'($urandom_range(65535, 1)));
          send_idle = 0;
          recv_idle = 0;
        end
        5: begin
          write_reg(oels_pkg::REG_MIN_CUTOFF, oels_pkg::MIN_CUTOFF_RST);
          write_reg(oels_pkg::REG_SPEED_GAIN, oels_pkg::SPEED_GAIN_RST);
          write_reg(oels_pkg::REG_DERIV_CUTOFF, oels_pkg::DERIV_CUTOFF_RST);
        end
        default: ;
      endcase
      add_random(130);
      wait (sample_q.size() == 0);
      // hold the sender until the pipeline has delivered everything
      hold_send = 1'b1;
      add_random(130);
      wait (smooth_q.size() == 0);
      hold_send = 1'b0;
      drain();
    end

    repeat (LATENCY + 20) @(posedge clk_i);
    if (smooth_q.size() != 0) begin
      $error("%0d results never arrived", smooth_q.size());
      fails++;
    end
    if (fails == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
